FILE: rtl/assert_macros.svh
// Assertion helpers for the stress update block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define JSU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define JSU_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/jsu_pkg.sv
`default_nettype none
package jsu_pkg;

  localparam int GRAD_W     = 32;
  localparam int CFG_W      = 48;
  localparam int DT_W       = 32;
  localparam int NUM_COL    = 3;
  localparam int DIG_W      = 12;
  localparam int NUM_DIG    = 3;
  localparam int BOP_W      = NUM_DIG * DIG_W;
  localparam int TRACE_W    = GRAD_W + 3;
  localparam int ACC_W      = 128;
  localparam int FRAC_SHIFT = 61;
  localparam int GAIN_SHIFT = 24;

  typedef logic [1:0] idx_t;

  localparam idx_t ROW_LAST = 2'd2;
  localparam idx_t ROW_SKIP = 2'd3;
  localparam idx_t IDX_LAST = 2'd2;
  localparam idx_t DIG_LAST = idx_t'(NUM_DIG - 1);

  typedef enum logic [1:0] {
    CFG_SHEAR = 2'd0,
    CFG_LAME  = 2'd1,
    CFG_DT    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MS_NONE,
    MS_WT,
    MS_TW,
    MS_SHEAR,
    MS_LAME,
    MS_DT
  } msrc_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PASS_RD,
    S_PASS_OUT,
    S_TR_RD,
    S_TR_ADD,
    S_INIT_RD,
    S_INIT,
    S_WT_RD,
    S_WT_MUL,
    S_TW_RD,
    S_TW_MUL,
    S_G_RD,
    S_G_MUL,
    S_L_MUL,
    S_D_MUL,
    S_FIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic  wr;
    logic  trace_clr;
    logic  trace_add;
    logic  acc_init;
    msrc_t src;
    idx_t  digit;
    logic  fin;
    logic  pass;
    logic  push;
    logic  last;
    idx_t  i;
    idx_t  j;
    idx_t  k;
    idx_t  ga;
    idx_t  gb;
    idx_t  sa;
    idx_t  sb;
  } jsu_cmd_t;

  typedef struct packed {
    logic out_full;
  } jsu_stat_t;

endpackage
`default_nettype wire

FILE: rtl/jsu_in_if.sv
`default_nettype none
interface jsu_in_if import jsu_pkg::*; #(parameter int SB = 48) ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               row;
  logic signed [GRAD_W-1:0] grad_c0;
  logic signed [GRAD_W-1:0] grad_c1;
  logic signed [GRAD_W-1:0] grad_c2;
  logic signed [SB-1:0]     stress_c0;
  logic signed [SB-1:0]     stress_c1;
  logic signed [SB-1:0]     stress_c2;
  logic                     active;

  modport source (output valid, row, grad_c0, grad_c1, grad_c2,
                  stress_c0, stress_c1, stress_c2, active, input ready);
  modport sink (input valid, row, grad_c0, grad_c1, grad_c2,
                stress_c0, stress_c1, stress_c2, active, output ready);
endinterface
`default_nettype wire

FILE: rtl/jsu_out_if.sv
`default_nettype none
interface jsu_out_if #(parameter int SB = 48) ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           out_row;
  logic signed [SB-1:0] new_c0;
  logic signed [SB-1:0] new_c1;
  logic signed [SB-1:0] new_c2;
  logic                 last;

  modport source (output valid, out_row, new_c0, new_c1, new_c2, last, input ready);
  modport sink (input valid, out_row, new_c0, new_c1, new_c2, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/jsu_cfg_if.sv
`default_nettype none
interface jsu_cfg_if import jsu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       index;
  logic [CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/jsu_ctrl.sv
`default_nettype none
module jsu_ctrl import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  idx_t      in_row,
  input  logic      in_active,
  input  jsu_stat_t stat,
  output logic      in_ready,
  output jsu_cmd_t  cmd
);

  state_t state, state_next;
  idx_t   i, i_next;
  idx_t   j, j_next;
  idx_t   k, k_next;
  idx_t   digit, digit_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
      digit <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
      digit <= digit_next;
    end
  end

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    digit_next = digit;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.src    = MS_NONE;
    cmd.i      = i;
    cmd.j      = j;
    cmd.k      = k;
    cmd.digit  = digit;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr = (in_row != ROW_SKIP);
          if (in_row == ROW_LAST) begin
            i_next        = '0;
            j_next        = '0;
            k_next        = '0;
            digit_next    = '0;
            cmd.trace_clr = 1'b1;
            state_next    = in_active ? S_TR_RD : S_PASS_RD;
          end
        end
      end
      S_PASS_RD: begin
        cmd.sa     = i;
        state_next = S_PASS_OUT;
      end
      S_PASS_OUT: begin
        cmd.sa = i;
        if (!stat.out_full) begin
          cmd.push = 1'b1;
          cmd.pass = 1'b1;
          cmd.last = (i == IDX_LAST);
          if (i == IDX_LAST) begin
            state_next = S_IDLE;
          end else begin
            i_next     = i + 2'd1;
            state_next = S_PASS_RD;
          end
        end
      end
      S_TR_RD: begin
        cmd.ga     = k;
        state_next = S_TR_ADD;
      end
      S_TR_ADD: begin
        cmd.ga        = k;
        cmd.trace_add = 1'b1;
        if (k == IDX_LAST) begin
          k_next     = '0;
          state_next = S_INIT_RD;
        end else begin
          k_next     = k + 2'd1;
          state_next = S_TR_RD;
        end
      end
      S_INIT_RD: begin
        cmd.sa     = i;
        state_next = S_INIT;
      end
      S_INIT: begin
        cmd.sa       = i;
        cmd.acc_init = 1'b1;
        k_next       = '0;
        digit_next   = '0;
        state_next   = S_WT_RD;
      end
      S_WT_RD, S_WT_MUL: begin
        cmd.ga = i;
        cmd.gb = k;
        cmd.sb = k;
        if (state == S_WT_RD) begin
          state_next = S_WT_MUL;
        end else begin
          cmd.src = MS_WT;
          if (digit == DIG_LAST) begin
            digit_next = '0;
            state_next = S_TW_RD;
          end else begin
            digit_next = digit + 2'd1;
          end
        end
      end
      S_TW_RD, S_TW_MUL: begin
        cmd.ga = k;
        cmd.gb = j;
        cmd.sa = i;
        if (state == S_TW_RD) begin
          state_next = S_TW_MUL;
        end else begin
          cmd.src = MS_TW;
          if (digit == DIG_LAST) begin
            digit_next = '0;
            if (k == IDX_LAST) begin
              k_next     = '0;
              state_next = S_G_RD;
            end else begin
              k_next     = k + 2'd1;
              state_next = S_WT_RD;
            end
          end else begin
            digit_next = digit + 2'd1;
          end
        end
      end
      S_G_RD, S_G_MUL: begin
        cmd.ga = i;
        cmd.gb = j;
        if (state == S_G_RD) begin
          state_next = S_G_MUL;
        end else begin
          cmd.src = MS_SHEAR;
          if (digit == DIG_LAST) begin
            digit_next = '0;
            state_next = (i == j) ? S_L_MUL : S_D_MUL;
          end else begin
            digit_next = digit + 2'd1;
          end
        end
      end
      S_L_MUL: begin
        cmd.src = MS_LAME;
        if (digit == DIG_LAST) begin
          digit_next = '0;
          state_next = S_D_MUL;
        end else begin
          digit_next = digit + 2'd1;
        end
      end
      S_D_MUL: begin
        cmd.src = MS_DT;
        if (digit == DIG_LAST) begin
          digit_next = '0;
          state_next = S_FIN;
        end else begin
          digit_next = digit + 2'd1;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (j == IDX_LAST) begin
          state_next = S_OUT;
        end else begin
          j_next     = j + 2'd1;
          state_next = S_INIT_RD;
        end
      end
      S_OUT: begin
        if (!stat.out_full) begin
          cmd.push = 1'b1;
          cmd.last = (i == IDX_LAST);
          j_next   = '0;
          if (i == IDX_LAST) begin
            state_next = S_IDLE;
          end else begin
            i_next     = i + 2'd1;
            state_next = S_INIT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/jsu_datapath.sv
`default_nettype none
module jsu_datapath import jsu_pkg::*; #(
  parameter int SB = 48
) (
  input  logic                     clk,
  input  logic                     rst,
  input  jsu_cmd_t                 cmd,
  output jsu_stat_t                stat,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  idx_t                     in_row,
  input  logic signed [GRAD_W-1:0] in_g0,
  input  logic signed [GRAD_W-1:0] in_g1,
  input  logic signed [GRAD_W-1:0] in_g2,
  input  logic signed [SB-1:0]     in_t0,
  input  logic signed [SB-1:0]     in_t1,
  input  logic signed [SB-1:0]     in_t2,
  input  logic                     out_ready,
  output logic                     out_valid,
  output idx_t                     out_row,
  output logic signed [SB-1:0]     out_c0,
  output logic signed [SB-1:0]     out_c1,
  output logic signed [SB-1:0]     out_c2,
  output logic                     out_last
);

  localparam int AW   = SB + BOP_W;
  localparam int PW   = AW + DIG_W + 1;
  localparam int HI_W = ACC_W - FRAC_SHIFT - SB + 1;

  localparam logic [SB-1:0]    SAT_MAX = {1'b0, {(SB - 1){1'b1}}};
  localparam logic [SB-1:0]    SAT_MIN = {1'b1, {(SB - 1){1'b0}}};
  localparam logic [ACC_W-1:0] HALF    = ACC_W'(1) << (FRAC_SHIFT - 1);

  logic [NUM_COL-1:0][GRAD_W-1:0] grad_mem [NUM_COL];
  logic [NUM_COL-1:0][SB-1:0]     stress_mem [NUM_COL];
  logic [NUM_COL-1:0][GRAD_W-1:0] ga_row, gb_row;
  logic [NUM_COL-1:0][SB-1:0]     sa_row, sb_row;

  logic [CFG_W-1:0]          shear;
  logic signed [CFG_W-1:0]   lame;
  logic [DT_W-1:0]           dt;
  logic signed [TRACE_W-1:0] trace;
  logic signed [AW-1:0]      comm;
  logic [ACC_W-1:0]          acc;
  logic [NUM_COL-1:0][SB-1:0] res_col;
  logic [NUM_COL-1:0][SB-1:0] out_cols;
  logic                      out_full;

  logic signed [GRAD_W:0]    g_diff_wt, g_diff_tw, g_sum;
  logic signed [AW-1:0]      op_a;
  logic signed [BOP_W-1:0]   op_b;
  logic signed [DIG_W:0]     dig;
  logic signed [PW-1:0]      prod;
  logic [ACC_W-1:0]          term_acc;
  logic [AW-1:0]             term_comm;
  logic [7:0]                shamt;
  logic [ACC_W-1:0]          rnd;
  logic [HI_W-1:0]           rnd_hi;
  logic [SB-1:0]             sat_val;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      grad_mem[in_row]   <= {in_g2, in_g1, in_g0};
      stress_mem[in_row] <= {in_t2, in_t1, in_t0};
    end
    ga_row <= grad_mem[cmd.ga];
    gb_row <= grad_mem[cmd.gb];
    sa_row <= stress_mem[cmd.sa];
    sb_row <= stress_mem[cmd.sb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shear <= '0;
      lame  <= '0;
      dt    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHEAR: shear <= cfg_data;
        CFG_LAME:  lame  <= cfg_data;
        CFG_DT:    dt    <= cfg_data[DT_W-1:0];
        default:   ;
      endcase
    end
  end

  // D and W elements in units of 2^-21
  assign g_diff_wt = $signed({ga_row[cmd.k][GRAD_W-1], ga_row[cmd.k]})
                   - $signed({gb_row[cmd.i][GRAD_W-1], gb_row[cmd.i]});
  assign g_diff_tw = $signed({ga_row[cmd.j][GRAD_W-1], ga_row[cmd.j]})
                   - $signed({gb_row[cmd.k][GRAD_W-1], gb_row[cmd.k]});
  assign g_sum     = $signed({ga_row[cmd.j][GRAD_W-1], ga_row[cmd.j]})
                   + $signed({gb_row[cmd.i][GRAD_W-1], gb_row[cmd.i]});

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.src)
      MS_WT: begin
        op_a = AW'($signed(sb_row[cmd.j]));
        op_b = BOP_W'(g_diff_wt);
      end
      MS_TW: begin
        op_a = AW'($signed(sa_row[cmd.k]));
        op_b = BOP_W'(g_diff_tw);
      end
      MS_SHEAR: begin
        op_a = AW'($signed({1'b0, shear}));
        op_b = BOP_W'(g_sum);
      end
      MS_LAME: begin
        op_a = AW'(lame);
        op_b = BOP_W'(trace);
      end
      MS_DT: begin
        op_a = comm;
        op_b = BOP_W'($signed({1'b0, dt}));
      end
      default: ;
    endcase
  end

  // one 12-bit digit of op_b per cycle, top digit signed
  always_comb begin
    if (cmd.digit == DIG_LAST) begin
      dig = $signed({op_b[BOP_W-1], op_b[BOP_W-1 -: DIG_W]});
    end else begin
      dig = $signed({1'b0, op_b[cmd.digit * DIG_W +: DIG_W]});
    end
    prod  = PW'(op_a) * PW'(dig);
    shamt = 8'(cmd.digit) * 8'(DIG_W);
    if (cmd.src == MS_SHEAR || cmd.src == MS_LAME) begin
      shamt = shamt + 8'(GAIN_SHIFT);
    end
    term_acc  = ACC_W'(prod) << shamt;
    term_comm = AW'(prod) << shamt;
  end

  assign rnd     = acc + HALF;
  assign rnd_hi  = rnd[ACC_W-1 -: HI_W];
  assign sat_val = ((&rnd_hi) || !(|rnd_hi)) ? rnd[FRAC_SHIFT +: SB]
                 : (rnd[ACC_W-1] ? SAT_MIN : SAT_MAX);

  always_ff @(posedge clk) begin
    if (cmd.trace_clr) begin
      trace <= '0;
    end else if (cmd.trace_add) begin
      trace <= trace + (TRACE_W'($signed(ga_row[cmd.ga])) <<< 1);
    end
    if (cmd.acc_init) begin
      acc  <= ACC_W'($signed(sa_row[cmd.j])) << FRAC_SHIFT;
      comm <= '0;
    end else begin
      case (cmd.src)
        MS_WT:    comm <= comm + $signed(term_comm);
        MS_TW:    comm <= comm - $signed(term_comm);
        MS_SHEAR,
        MS_LAME,
        MS_DT:    acc <= acc + term_acc;
        default:  ;
      endcase
    end
    if (cmd.fin) begin
      res_col[cmd.j] <= sat_val;
    end
    if (cmd.push) begin
      out_cols <= cmd.pass ? sa_row : res_col;
      out_row  <= cmd.i;
      out_last <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.push) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  assign stat.out_full = out_full;
  assign out_valid     = out_full;
  assign out_c0        = out_cols[0];
  assign out_c1        = out_cols[1];
  assign out_c2        = out_cols[2];

endmodule
`default_nettype wire

FILE: rtl/jaumann_stress_update.sv
`default_nettype none
`include "assert_macros.svh"
// Jaumann-rate stress update. A particle comes in as three transactions, rows 0, 1 and 2
// of its velocity gradient and old stress; rows 0 and 1 are stored while the block stays
// ready, and row 2 starts the update, during which no new transaction is taken. An
// inactive particle returns its old stress unchanged. For an active one, a trace pass
// comes first; then each of the nine new elements runs its six commutator products, the
// gain products and the timestep product through one shared multiplier that handles a
// 12-bit digit per cycle, and each finished row then loads the output register. Results
// leave through an output register, so the next row is computed while a finished row
// waits; a second finished row holds the block until the first is taken.
module jaumann_stress_update import jsu_pkg::*; #(
  parameter int STRESS_BITS = 48
) (
  input logic        clk,
  input logic        rst,
  jsu_in_if.sink     upd_in,
  jsu_out_if.source  upd_out,
  jsu_cfg_if.sink    cfg
);

  jsu_cmd_t  cmd;
  jsu_stat_t stat;
  logic      in_ready;

  assign upd_in.ready = in_ready;
  assign cfg.ready    = 1'b1;

  jsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (upd_in.valid),
    .in_row   (upd_in.row),
    .in_active(upd_in.active),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  jsu_datapath #(.SB(STRESS_BITS)) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .cfg_we   (cfg.valid),
    .cfg_index(cfg.index),
    .cfg_data (cfg.data),
    .in_row   (upd_in.row),
    .in_g0    (upd_in.grad_c0),
    .in_g1    (upd_in.grad_c1),
    .in_g2    (upd_in.grad_c2),
    .in_t0    (upd_in.stress_c0),
    .in_t1    (upd_in.stress_c1),
    .in_t2    (upd_in.stress_c2),
    .out_ready(upd_out.ready),
    .out_valid(upd_out.valid),
    .out_row  (upd_out.out_row),
    .out_c0   (upd_out.new_c0),
    .out_c1   (upd_out.new_c1),
    .out_c2   (upd_out.new_c2),
    .out_last (upd_out.last)
  );

  `JSU_ASSERT_IMPLY(a_last_on_row2, clk, rst, (upd_out.valid && upd_out.last), (upd_out.out_row == ROW_LAST))
  `JSU_ASSERT_IMPLY(a_no_row3_out, clk, rst, upd_out.valid, (upd_out.out_row != ROW_SKIP))
  `JSU_ASSERT_NEXT(a_busy_after_row2, clk, rst, (upd_in.valid && in_ready && upd_in.row == ROW_LAST), !in_ready)

endmodule
`default_nettype wire
